>>> hdl/asc_pkg.sv
package asc_pkg;

  localparam int SLOTS_DEF       = 256;
  localparam int SLOTS_PER_ROW_DEF = 16;
  localparam int CELL_WIDTH_DEF  = 64;
  localparam int CELL_HEIGHT_DEF = 64;

  localparam int          KEY_W    = 19;
  localparam logic [31:0] KEY_MASK = 32'h0007_FFFF;

  // The key memory holds one row of this many keys per word.
  localparam int LANES  = 64;
  localparam int LANE_W = $clog2(LANES);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_INVAL = 1'b1;

  typedef enum logic [2:0] {
    STAT_HIT,
    STAT_LOADED,
    STAT_FULL,
    STAT_REMOVED,
    STAT_ABSENT
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic rd;
    logic set;
    logic clr;
  } ks_ctrl_t;

  typedef struct packed {
    logic pop_rd;
    logic pop_commit;
    logic push;
  } fs_ctrl_t;

  function automatic int rows_of(int slots);
    return (slots + LANES - 1) >> LANE_W;
  endfunction

  function automatic int row_w(int slots);
    int rows;
    rows = rows_of(slots);
    return (rows > 1) ? $clog2(rows) : 1;
  endfunction

  function automatic int idx_w(int slots);
    return LANE_W + row_w(slots);
  endfunction

  function automatic int cnt_w(int slots);
    return $clog2(slots + 1);
  endfunction

  function automatic int addr_w(int slots);
    return (slots > 1) ? $clog2(slots) : 1;
  endfunction

  function automatic int col_w(int per_row);
    return (per_row > 1) ? $clog2(per_row) : 1;
  endfunction

endpackage

>>> hdl/asc_key_search.sv
module asc_key_search #(
  parameter int SLOTS = asc_pkg::SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  asc_pkg::ks_ctrl_t                   ctrl,
  input  logic [asc_pkg::row_w(SLOTS)-1:0]    rd_row,
  input  logic [asc_pkg::idx_w(SLOTS)-1:0]    wr_slot,
  input  logic [asc_pkg::KEY_W-1:0]           wr_key,
  input  logic [asc_pkg::idx_w(SLOTS)-1:0]    clr_slot,
  input  logic [asc_pkg::KEY_W-1:0]           key,
  output logic                                hit,
  output logic [asc_pkg::idx_w(SLOTS)-1:0]    hit_slot
);
  import asc_pkg::*;

  localparam int ROWS = rows_of(SLOTS);
  localparam int RW   = row_w(SLOTS);
  localparam int IW   = idx_w(SLOTS);

  logic [LANES-1:0][KEY_W-1:0] key_mem [ROWS];
  logic [LANES-1:0][KEY_W-1:0] key_rd;
  logic [RW-1:0]               cmp_row;
  logic [ROWS*LANES-1:0]       valid;
  logic [LANES-1:0]            row_valid;
  logic [LANES-1:0]            match;
  logic [LANE_W-1:0]           hit_lane;

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      key_rd  <= key_mem[rd_row];
      cmp_row <= rd_row;
    end
    if (ctrl.set) begin
      key_mem[wr_slot[IW-1:LANE_W]][wr_slot[LANE_W-1:0]] <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ctrl.set) begin
        valid[wr_slot] <= 1'b1;
      end
      if (ctrl.clr) begin
        valid[clr_slot] <= 1'b0;
      end
    end
  end

  // Keys are unique among valid entries, so at most one lane matches and
  // the lane number can be formed by OR-ing the matching lane indexes.
  always_comb begin
    row_valid = valid[{cmp_row, LANE_W'(0)} +: LANES];
    hit_lane  = '0;
    for (int l = 0; l < LANES; l++) begin
      match[l] = row_valid[l] && (key_rd[l] == key);
      if (match[l]) begin
        hit_lane = hit_lane | LANE_W'(l);
      end
    end
  end

  assign hit      = |match;
  assign hit_slot = {cmp_row, hit_lane};

endmodule

>>> hdl/asc_free_stack.sv
module asc_free_stack #(
  parameter int SLOTS         = asc_pkg::SLOTS_DEF,
  parameter int SLOTS_PER_ROW = asc_pkg::SLOTS_PER_ROW_DEF,
  parameter int CROW_W        = 5
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  asc_pkg::fs_ctrl_t                        ctrl,
  input  logic [asc_pkg::idx_w(SLOTS)-1:0]         push_slot,
  input  logic [asc_pkg::col_w(SLOTS_PER_ROW)-1:0] push_col,
  input  logic [CROW_W-1:0]                        push_row,
  output logic                                     empty,
  output logic [asc_pkg::idx_w(SLOTS)-1:0]         pop_slot,
  output logic [asc_pkg::col_w(SLOTS_PER_ROW)-1:0] pop_col,
  output logic [CROW_W-1:0]                        pop_row
);
  import asc_pkg::*;

  localparam int IW       = idx_w(SLOTS);
  localparam int CW       = cnt_w(SLOTS);
  localparam int AW       = addr_w(SLOTS);
  localparam int CLW      = col_w(SLOTS_PER_ROW);
  localparam int EW       = IW + CLW + CROW_W;
  localparam int COL_INIT = SLOTS % SLOTS_PER_ROW;
  localparam int ROW_INIT = SLOTS / SLOTS_PER_ROW;

  logic [EW-1:0]     stack_mem [SLOTS];
  logic [EW-1:0]     rd_data;
  logic [CW-1:0]     count;
  // Lowest fill level reached since reset; entries below it have never
  // been written, so a pop at that level is formed from lo, lo_col, lo_row.
  logic [CW-1:0]     lo;
  logic [CLW-1:0]    lo_col;
  logic [CROW_W-1:0] lo_row;
  logic [CLW-1:0]    dec_col;
  logic [CROW_W-1:0] dec_row;
  logic              fresh;
  logic [IW-1:0]     fresh_slot;
  logic [CLW-1:0]    fresh_col;
  logic [CROW_W-1:0] fresh_row;

  always_comb begin
    if (lo_col == '0) begin
      dec_col = CLW'(SLOTS_PER_ROW - 1);
      dec_row = lo_row - 1'b1;
    end else begin
      dec_col = lo_col - 1'b1;
      dec_row = lo_row;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop_rd) begin
      rd_data    <= stack_mem[AW'(count - 1'b1)];
      fresh      <= (count == lo);
      fresh_slot <= IW'(lo - 1'b1);
      fresh_col  <= dec_col;
      fresh_row  <= dec_row;
    end
    if (ctrl.push) begin
      stack_mem[AW'(count)] <= {push_slot, push_col, push_row};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= CW'(SLOTS);
      lo     <= CW'(SLOTS);
      lo_col <= CLW'(COL_INIT);
      lo_row <= CROW_W'(ROW_INIT);
    end else begin
      if (ctrl.pop_commit) begin
        count <= count - 1'b1;
        if (count == lo) begin
          lo     <= lo - 1'b1;
          lo_col <= dec_col;
          lo_row <= dec_row;
        end
      end else if (ctrl.push) begin
        count <= count + 1'b1;
      end
    end
  end

  assign empty = (count == '0);

  always_comb begin
    if (fresh) begin
      pop_slot = fresh_slot;
      pop_col  = fresh_col;
      pop_row  = fresh_row;
    end else begin
      {pop_slot, pop_col, pop_row} = rd_data;
    end
  end

endmodule

>>> hdl/atlas_slot_cache.sv
// Atlas slot cache: maps 19-bit image keys to atlas cells.
// Command port: a word is taken at a clock edge with start high and busy low.
// command 0 looks a key up and, on a miss, takes a free slot and records the
// clamped sprite size; command 1 frees the slot held by the key.
// Result port: done is high for exactly one cycle with status, slot_number
// and the cell rectangle; the receiver cannot hold it off.
// Flow: the key memory is scanned one row of 64 keys per cycle over ROWS
// rows, where ROWS is SLOTS / 64 rounded up, followed by an update state
// and an output state; done is registered from the output state. busy
// drops in the cycle that shows done, so a new word can be taken then;
// no word is taken while the last one is still in flight.
// Reset: all entries invalid, every slot free; the first slot handed out is
// SLOTS - 1. No clearing pass is needed, so a word can be taken right after
// reset is released.
module atlas_slot_cache #(
  parameter int SLOTS         = asc_pkg::SLOTS_DEF,
  parameter int SLOTS_PER_ROW = asc_pkg::SLOTS_PER_ROW_DEF,
  parameter int CELL_WIDTH    = asc_pkg::CELL_WIDTH_DEF,
  parameter int CELL_HEIGHT   = asc_pkg::CELL_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        command,
  input  logic [31:0] image_key,
  input  logic [11:0] sprite_width,
  input  logic [11:0] sprite_height,
  output logic        done,
  output logic [2:0]  status,
  output logic [7:0]  slot_number,
  output logic [9:0]  left_x,
  output logic [9:0]  top_y,
  output logic [10:0] right_x,
  output logic [10:0] bottom_y
);
  import asc_pkg::*;

  localparam int ROWS = rows_of(SLOTS);
  localparam int RW   = row_w(SLOTS);
  localparam int IW   = idx_w(SLOTS);
  localparam int CLW  = col_w(SLOTS_PER_ROW);
  localparam int CRW  = $clog2(SLOTS / SLOTS_PER_ROW + 1);
  localparam int WW   = $clog2(CELL_WIDTH + 1);
  localparam int HW   = $clog2(CELL_HEIGHT + 1);
  localparam int AW   = CLW + CRW + WW + HW;

  state_t         state;
  state_t         state_next;
  ks_ctrl_t       ks_ctrl;
  fs_ctrl_t       fs_ctrl;
  logic           accept;

  logic           cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [WW-1:0]  w_q;
  logic [HW-1:0]  h_q;
  logic [RW-1:0]  srch_row;
  logic [RW-1:0]  rd_row;
  logic           found_q;
  logic [IW-1:0]  found_slot_q;
  logic [IW-1:0]  res_slot;
  status_t        status_q;

  logic           hit;
  logic [IW-1:0]  hit_slot;
  logic           empty;
  logic [IW-1:0]  pop_slot;
  logic [CLW-1:0] pop_col;
  logic [CRW-1:0] pop_row;
  logic           load_new;

  logic [AW-1:0]  attr_mem [ROWS*LANES];
  logic [AW-1:0]  attr_rd;
  logic           attr_re;
  logic           attr_we;

  logic [CLW-1:0] col_s;
  logic [CRW-1:0] row_s;
  logic [WW-1:0]  w_s;
  logic [HW-1:0]  h_s;
  logic [31:0]    left_full;
  logic [31:0]    top_full;
  logic           has_rect;

  assign accept   = start && !busy;
  assign busy     = (state != ST_IDLE);
  assign load_new = (cmd_q == CMD_LOAD) && !found_q && !empty;

  asc_key_search #(
    .SLOTS(SLOTS)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ks_ctrl),
    .rd_row   (rd_row),
    .wr_slot  (pop_slot),
    .wr_key   (key_q),
    .clr_slot (found_slot_q),
    .key      (key_q),
    .hit      (hit),
    .hit_slot (hit_slot)
  );

  asc_free_stack #(
    .SLOTS        (SLOTS),
    .SLOTS_PER_ROW(SLOTS_PER_ROW),
    .CROW_W       (CRW)
  ) u_stack (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (fs_ctrl),
    .push_slot (res_slot),
    .push_col  (attr_rd[AW-1 -: CLW]),
    .push_row  (attr_rd[WW+HW +: CRW]),
    .empty     (empty),
    .pop_slot  (pop_slot),
    .pop_col   (pop_col),
    .pop_row   (pop_row)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (srch_row == RW'(ROWS - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_OUT;
      ST_OUT:    state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ks_ctrl = '0;
    fs_ctrl = '0;
    rd_row  = '0;
    attr_re = 1'b0;
    attr_we = 1'b0;
    unique case (state)
      ST_IDLE: begin
        ks_ctrl.rd     = accept;
        fs_ctrl.pop_rd = accept && !empty;
      end
      ST_SEARCH: begin
        ks_ctrl.rd = (srch_row != RW'(ROWS - 1));
        rd_row     = RW'(srch_row + 1'b1);
      end
      ST_FINISH: begin
        ks_ctrl.set        = load_new;
        ks_ctrl.clr        = (cmd_q == CMD_INVAL) && found_q;
        fs_ctrl.pop_commit = load_new;
        attr_we            = load_new;
        attr_re            = found_q;
      end
      ST_OUT: begin
        fs_ctrl.push = (status_q == STAT_REMOVED);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[pop_slot] <= {pop_col, pop_row, w_q, h_q};
    end
    if (attr_re) begin
      attr_rd <= attr_mem[found_slot_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found_q <= 1'b0;
    end else if (accept) begin
      found_q <= 1'b0;
    end else if (state == ST_SEARCH && hit) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q    <= command;
      key_q    <= KEY_W'(image_key & KEY_MASK);
      w_q      <= (sprite_width > 12'(CELL_WIDTH)) ? WW'(CELL_WIDTH) : WW'(sprite_width);
      h_q      <= (sprite_height > 12'(CELL_HEIGHT)) ? HW'(CELL_HEIGHT)
                                                      : HW'(sprite_height);
      srch_row <= '0;
    end else if (state == ST_SEARCH) begin
      srch_row <= RW'(srch_row + 1'b1);
      if (hit) begin
        found_slot_q <= hit_slot;
      end
    end
    if (state == ST_FINISH) begin
      res_slot <= found_q ? found_slot_q : pop_slot;
      if (cmd_q == CMD_LOAD) begin
        if (found_q) begin
          status_q <= STAT_HIT;
        end else if (empty) begin
          status_q <= STAT_FULL;
        end else begin
          status_q <= STAT_LOADED;
        end
      end else begin
        status_q <= found_q ? STAT_REMOVED : STAT_ABSENT;
      end
    end
  end

  // A freshly loaded entry takes its cell from the stack and its size from
  // the command; hits and removals take both from the attribute memory.
  always_comb begin
    if (status_q == STAT_LOADED) begin
      col_s = pop_col;
      row_s = pop_row;
      w_s   = w_q;
      h_s   = h_q;
    end else begin
      {col_s, row_s, w_s, h_s} = attr_rd;
    end
    has_rect  = (status_q == STAT_HIT) || (status_q == STAT_LOADED) ||
                (status_q == STAT_REMOVED);
    left_full = 32'(CELL_WIDTH) * 32'(col_s);
    top_full  = 32'(CELL_HEIGHT) * 32'(row_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT) begin
      status <= status_q;
      if (has_rect) begin
        slot_number <= 8'(res_slot);
        left_x      <= left_full[9:0];
        top_y       <= top_full[9:0];
        right_x     <= left_full[10:0] + 11'(w_s);
        bottom_y    <= top_full[10:0] + 11'(h_s);
      end else begin
        slot_number <= '0;
        left_x      <= '0;
        top_y       <= '0;
        right_x     <= '0;
        bottom_y    <= '0;
      end
    end
  end

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(ROWS + 3) done)
    else $error("result did not follow the accepted word after the scan");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("one word produced more than one result");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STAT_FULL || status == STAT_ABSENT)) |->
      (slot_number == '0 && left_x == '0 && top_y == '0 &&
       right_x == '0 && bottom_y == '0))
    else $error("result without an entry carries a nonzero rectangle");

endmodule

>>> bench/tb_atlas_slot_cache.sv
module tb_atlas_slot_cache;
  timeunit 1ns;
  timeprecision 1ps;

  import asc_pkg::*;

  localparam int NSLOT      = SLOTS_DEF;
  localparam int PER_ROW    = SLOTS_PER_ROW_DEF;
  localparam int CELL_W     = CELL_WIDTH_DEF;
  localparam int CELL_H     = CELL_HEIGHT_DEF;
  localparam int CYCLE_CAP  = 200000;
  localparam int TAIL_WAIT  = 20;
  localparam int MAX_REPORT = 10;

  typedef struct {
    status_t     stat;
    logic [7:0]  slot;
    logic [9:0]  left;
    logic [9:0]  top;
    logic [10:0] right;
    logic [10:0] bottom;
  } cache_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        command = CMD_LOAD;
  logic [31:0] image_key = '0;
  logic [11:0] sprite_width = '0;
  logic [11:0] sprite_height = '0;
  logic        done;
  logic [2:0]  status;
  logic [7:0]  slot_number;
  logic [9:0]  left_x;
  logic [9:0]  top_y;
  logic [10:0] right_x;
  logic [10:0] bottom_y;

  // Shadow copy of the slot table and the free-slot stack.
  logic [18:0] slot_key  [NSLOT];
  logic        slot_used [NSLOT];
  logic [6:0]  slot_w    [NSLOT];
  logic [6:0]  slot_h    [NSLOT];
  logic [7:0]  free_list [NSLOT];
  int          free_total;

  cache_result_t pending_results[$];
  cache_result_t want;
  int            mismatch_count = 0;
  int            cycle_count = 0;
  bit            burst_mode = 1'b0;
  logic [31:0]   fill_keys[$];

  atlas_slot_cache u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .image_key    (image_key),
    .sprite_width (sprite_width),
    .sprite_height(sprite_height),
    .done         (done),
    .status       (status),
    .slot_number  (slot_number),
    .left_x       (left_x),
    .top_y        (top_y),
    .right_x      (right_x),
    .bottom_y     (bottom_y)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic cache_result_t cell_result(status_t st, int s);
    cache_result_t r;
    int col;
    int row;
    int lx;
    int ty;
    col = s % PER_ROW;
    row = s / PER_ROW;
    lx = CELL_W * col;
    ty = CELL_H * row;
    r.stat = st;
    r.slot = s[7:0];
    r.left = lx[9:0];
    r.top = ty[9:0];
    r.right = 11'(lx + slot_w[s]);
    r.bottom = 11'(ty + slot_h[s]);
    return r;
  endfunction

  function automatic cache_result_t predict_word(logic cmd, logic [31:0] key_in,
                                                 logic [11:0] w_in, logic [11:0] h_in);
    cache_result_t r;
    logic [18:0]   k;
    int            found;
    int            s;
    k = key_in[18:0];
    found = -1;
    for (int i = 0; i < NSLOT; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;
    end
    if (cmd == CMD_LOAD) begin
      if (found >= 0) begin
        r = cell_result(STAT_HIT, found);
      end else if (free_total == 0) begin
        r = '{STAT_FULL, 8'd0, 10'd0, 10'd0, 11'd0, 11'd0};
      end else begin
        free_total--;
        s = free_list[free_total];
        slot_key[s] = k;
        slot_used[s] = 1'b1;
        slot_w[s] = (w_in > CELL_W) ? 7'(CELL_W) : w_in[6:0];
        slot_h[s] = (h_in > CELL_H) ? 7'(CELL_H) : h_in[6:0];
        r = cell_result(STAT_LOADED, s);
      end
    end else begin
      if (found < 0) begin
        r = '{STAT_ABSENT, 8'd0, 10'd0, 10'd0, 11'd0, 11'd0};
      end else begin
        r = cell_result(STAT_REMOVED, found);
        slot_used[found] = 1'b0;
        free_list[free_total] = found[7:0];
        free_total++;
      end
    end
    return r;
  endfunction

  // start is left high after a word is taken, so a back-to-back word keeps
  // it high; it is only lowered when the next word waits or results drain.
  task automatic send_word(input logic cmd, input logic [31:0] key,
                           input logic [11:0] w, input logic [11:0] h);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    image_key <= key;
    sprite_width <= w;
    sprite_height <= h;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.insert(pending_results.size(), predict_word(cmd, key, w, h));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic log_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORT) begin
      $display("[%0t] %s: got st=%0d slot=%0d rect=(%0d,%0d,%0d,%0d)", $realtime, what,
               status, slot_number, left_x, top_y, right_x, bottom_y);
      $display("        want st=%0d slot=%0d rect=(%0d,%0d,%0d,%0d)", want.stat, want.slot,
               want.left, want.top, want.right, want.bottom);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        want = '{STAT_HIT, 8'd0, 10'd0, 10'd0, 11'd0, 11'd0};
        log_failure("result with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.stat || slot_number !== want.slot || left_x !== want.left ||
            top_y !== want.top || right_x !== want.right || bottom_y !== want.bottom)
          log_failure("result mismatch");
      end
    end
  end

  task automatic test_directed();
    burst_mode = 1'b0;
    send_word(CMD_LOAD, 32'h0000_0000, 12'd0, 12'd0);
    send_word(CMD_LOAD, 32'h0007_FFFF, 12'd64, 12'd64);
    // Upper key bits are ignored, so this hits the entry just loaded.
    send_word(CMD_LOAD, 32'hFFFF_FFFF, 12'd1, 12'd1);
    send_word(CMD_LOAD, 32'h0000_0001, 12'd65, 12'hFFF);
    send_word(CMD_LOAD, 32'h0000_0002, 12'hFFF, 12'd1);
    send_word(CMD_LOAD, 32'hFFF8_0001, 12'd3, 12'd3);
    send_word(CMD_INVAL, 32'h0008_0002, 12'hFFF, 12'hFFF);
    send_word(CMD_INVAL, 32'h0000_0002, 12'd0, 12'd0);
    send_word(CMD_LOAD, 32'h0000_0003, 12'd63, 12'hAAA);
    send_word(CMD_INVAL, 32'h0000_0000, 12'd0, 12'd0);
    send_word(CMD_LOAD, 32'h0000_0005, 12'h555, 12'd63);
    send_word(CMD_LOAD, 32'hFFF8_0000, 12'd32, 12'd65);
    send_word(CMD_INVAL, 32'h1234_5678, 12'd0, 12'd0);
    send_word(CMD_INVAL, 32'hAAAA_AAAA, 12'h800, 12'h800);
    send_word(CMD_LOAD, 32'h5555_5555, 12'h7FF, 12'h040);
    send_word(CMD_INVAL, 32'h0007_FFFF, 12'd0, 12'd0);
    send_word(CMD_INVAL, 32'h0000_0001, 12'd0, 12'd0);
    drain_results();
  endtask

  // Fill every slot, overflow it, then free the whole table in random order.
  task automatic test_fill_and_empty();
    logic [31:0] r;
    logic [31:0] key;
    int          n;
    int          idx;
    n = 0;
    while (free_total > 0 && n < 2 * NSLOT) begin
      if (n % 32 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      r = $urandom();
      key = {r[31:19], 19'h40000 + 19'(n)};
      send_word(CMD_LOAD, key, 12'($urandom()), 12'($urandom_range(0, 80)));
      fill_keys.insert(fill_keys.size(), key);
      n++;
    end
    burst_mode = 1'b0;
    for (int i = 0; i < 4; i++)
      send_word(CMD_LOAD, {13'($urandom()), 19'h30000 + 19'(i)}, 12'd10, 12'd10);
    send_word(CMD_LOAD, fill_keys[0], 12'd0, 12'd0);
    send_word(CMD_INVAL, fill_keys[7], 12'd0, 12'd0);
    send_word(CMD_LOAD, 32'h0003_1234, 12'd70, 12'd5);
    fill_keys[7] = 32'h0003_1234;
    drain_results();
    n = 0;
    while (fill_keys.size() > 0) begin
      if (n % 32 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      idx = $urandom_range(0, fill_keys.size() - 1);
      send_word(CMD_INVAL, fill_keys[idx], 12'($urandom()), 12'($urandom()));
      fill_keys.delete(idx);
      n++;
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_words, input int pool_size,
                                     input int load_pct);
    logic [18:0] key_pool[$];
    logic [31:0] r;
    logic [31:0] key;
    logic [11:0] w;
    logic [11:0] h;
    logic        cmd;
    for (int i = 0; i < pool_size; i++) begin
      r = $urandom();
      key_pool.insert(key_pool.size(), r[18:0]);
    end
    for (int i = 0; i < n_words; i++) begin
      if (i % 32 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      cmd = ($urandom_range(0, 99) < load_pct) ? CMD_LOAD : CMD_INVAL;
      r = $urandom();
      if ($urandom_range(0, 9) == 0) key = $urandom();
      else key = {r[31:19], key_pool[$urandom_range(0, pool_size - 1)]};
      if ($urandom_range(0, 4) == 0) begin
        w = 12'($urandom());
        h = 12'($urandom());
      end else begin
        w = 12'($urandom_range(0, 80));
        h = 12'($urandom_range(0, 80));
      end
      send_word(cmd, key, w, h);
    end
    drain_results();
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      slot_used[i] = 1'b0;
      slot_key[i] = '0;
      slot_w[i] = '0;
      slot_h[i] = '0;
      free_list[i] = i[7:0];
    end
    free_total = NSLOT;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_fill_and_empty();
    test_random_traffic(500, 40, 55);
    test_random_traffic(400, 320, 80);
    test_random_traffic(230, 300, 30);
    repeat (TAIL_WAIT) @(posedge clk);
    mismatch_count += pending_results.size();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
